// ===== rtl/core/one_shot_timer_slot_table_macros.svh =====
// Assertion macros for the one-shot timer slot table.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef ONE_SHOT_TIMER_SLOT_TABLE_MACROS_SVH
`define ONE_SHOT_TIMER_SLOT_TABLE_MACROS_SVH

// same-cycle implication
`define OSTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OSTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/osts_pkg.sv =====
// Shared types and constants for the one-shot timer slot table.
// No dependencies.
package osts_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_REPORTS   = 16;
  localparam int CNT_W         = $clog2(MAX_REPORTS + 1);
  localparam int SLOT_W        = 4;

  typedef enum logic [1:0] {
    CMD_ARM    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ARMED     = 3'd0,
    KIND_NOSPACE   = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOTFOUND  = 3'd3,
    KIND_FIRED     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARM,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [15:0] handle;
    logic [31:0] tag;
  } entry_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [15:0]        handle;
    logic [31:0]        tag;
    logic               last;
  } result_t;

endpackage

// ===== rtl/core/osts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module osts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/osts_seq.sv =====
// Sequencer for the timer slot table: command FSM, active bits, slot scan.
// Depends on osts_pkg; drives the entry RAM ports of the top level.
module osts_seq import osts_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  output logic                                          busy,
  input  logic [1:0]                                    cmd_i,
  input  logic [31:0]                                   period_i,
  input  logic [15:0]                                   handle_i,
  input  logic [31:0]                                   tag_i,
  input  logic [63:0]                                   now_i,
  output logic                                          ram_we,
  output logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] ram_waddr,
  output entry_t                                        ram_wdata,
  output logic                                          ram_re,
  output logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] ram_raddr,
  input  entry_t                                        ram_rdata,
  output logic                                          emit_vld_o,
  output result_t                                       emit_o
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [31:0]          period_r, period_nxt;
  logic [15:0]          handle_r, handle_nxt;
  logic [31:0]          tag_r, tag_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 rd_more_r, rd_more_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                 found_r, found_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  result_t              pend_r, pend_nxt;
  logic [NUM_SLOTS-1:0] active_r, active_nxt;

  logic                 hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_more_r  <= 1'b0;
      cmp_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      active_r   <= '0;
      found_r    <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      rd_more_r  <= rd_more_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      active_r   <= active_nxt;
      found_r    <= found_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    period_r  <= period_nxt;
    handle_r  <= handle_nxt;
    tag_r     <= tag_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    pend_r    <= pend_nxt;
  end

  // compare stage sees the entry read in the previous cycle
  always_comb begin
    hit = 1'b0;
    if (cmp_vld_r && active_r[cmp_idx_r]) begin
      if (cmd_r == CMD_CANCEL) begin
        hit = (ram_rdata.handle == handle_r);
      end else begin
        hit = (ram_rdata.deadline < now_i);
      end
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign ram_re    = (state_r == ST_SCAN) && rd_more_r;
  assign ram_raddr = idx_r;
  assign ram_waddr = idx_r;
  assign ram_wdata = '{deadline: now_i + {32'd0, period_r}, handle: handle_r, tag: tag_r};
  assign ram_we    = (state_r == ST_ARM) && !active_r[idx_r];

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    period_nxt   = period_r;
    handle_nxt   = handle_r;
    tag_nxt      = tag_r;
    idx_nxt      = idx_r;
    rd_more_nxt  = rd_more_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    found_nxt    = found_r;
    cnt_nxt      = cnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    active_nxt   = active_r;
    emit_vld_o   = 1'b0;
    emit_o       = '{kind: KIND_ARMED, slot: '0, handle: '0, tag: '0, last: 1'b1};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt      = cmd_t'(cmd_i);
          period_nxt   = period_i;
          handle_nxt   = handle_i;
          tag_nxt      = tag_i;
          idx_nxt      = '0;
          rd_more_nxt  = 1'b1;
          found_nxt    = 1'b0;
          cnt_nxt      = '0;
          pend_vld_nxt = 1'b0;
          unique case (cmd_t'(cmd_i))
            CMD_ARM:    state_nxt = ST_ARM;
            CMD_CANCEL: state_nxt = ST_SCAN;
            CMD_TICK:   state_nxt = ST_SCAN;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_ARM: begin
        if (!active_r[idx_r]) begin
          active_nxt[idx_r] = 1'b1;
          emit_vld_o        = 1'b1;
          emit_o.kind       = KIND_ARMED;
          emit_o.slot       = SLOT_W'(idx_r);
          state_nxt         = ST_IDLE;
        end else if (idx_r == LAST_IDX) begin
          emit_vld_o  = 1'b1;
          emit_o.kind = KIND_NOSPACE;
          state_nxt   = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      ST_SCAN: begin
        // read issue stage
        cmp_vld_nxt = rd_more_r;
        cmp_idx_nxt = idx_r;
        if (rd_more_r) begin
          if (idx_r == LAST_IDX) begin
            rd_more_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end

        if (cmd_r == CMD_CANCEL) begin
          if (hit) begin
            active_nxt[cmp_idx_r] = 1'b0;
            found_nxt             = 1'b1;
          end
          if (cmp_vld_r && cmp_idx_r == LAST_IDX) begin
            emit_vld_o  = 1'b1;
            emit_o.kind = found_nxt ? KIND_CANCELLED : KIND_NOTFOUND;
            state_nxt   = ST_IDLE;
          end
        end else begin
          if (hit) begin
            active_nxt[cmp_idx_r] = 1'b0;
            if (ram_rdata.handle != 16'd0) begin
              // previous report is known not to be the final one
              if (pend_vld_r) begin
                emit_vld_o  = 1'b1;
                emit_o      = pend_r;
                emit_o.last = 1'b0;
              end
              pend_vld_nxt = 1'b1;
              pend_nxt     = '{kind: KIND_FIRED, slot: SLOT_W'(cmp_idx_r),
                               handle: ram_rdata.handle, tag: ram_rdata.tag,
                               last: 1'b1};
              cnt_nxt      = cnt_r + CNT_W'(1);
            end
          end
          if (cnt_nxt == CNT_W'(MAX_REPORTS)) begin
            // report limit reached: remaining slots wait for a later tick
            state_nxt   = ST_FLUSH;
            rd_more_nxt = 1'b0;
            cmp_vld_nxt = 1'b0;
          end else if (cmp_vld_r && cmp_idx_r == LAST_IDX) begin
            state_nxt = pend_vld_nxt ? ST_FLUSH : ST_IDLE;
          end
        end
      end

      ST_FLUSH: begin
        emit_vld_o   = 1'b1;
        emit_o       = pend_r;
        emit_o.last  = 1'b1;
        pend_vld_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/one_shot_timer_slot_table.sv =====
// One-shot timer slot table. An item is taken when start is high and busy is low; busy
// then stays high while the sequencer walks the slots one per cycle. Arm stops at the first
// free slot, or reports no space after the last; cancel scans every slot; tick scans every
// slot, with a flush step added when a timer fires, or stops early once 16 timers have
// fired. The pace is set by the slot scan: free bits are checked one per cycle, and entries
// come from the single read port of the slot RAM. Each result is shown for one cycle with
// out_strobe, in the cycle after it is formed; the receiver cannot stall, and the final
// result of an item carries out_last.
//
// Depends on osts_pkg, osts_seq, osts_ram and one_shot_timer_slot_table_macros.svh.
`include "one_shot_timer_slot_table_macros.svh"

module one_shot_timer_slot_table import osts_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_period_ticks,
  input  logic [15:0] in_handle,
  input  logic [31:0] in_argument_tag,
  output logic        out_strobe,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_slot,
  output logic [15:0] out_fired_handle,
  output logic [31:0] out_fired_tag,
  output logic        out_last
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic          tick_acc;
  logic [63:0]   now_r, now_nxt;
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic          emit_vld;
  result_t       emit;
  logic          strobe_r;
  result_t       res_r;
  logic          res_fire;

  assign tick_acc = start && !busy && (in_cmd == CMD_TICK);
  assign now_nxt  = tick_acc ? now_r + 64'd1 : now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      now_r    <= now_nxt;
      strobe_r <= emit_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_vld) begin
      res_r <= emit;
    end
  end

  osts_seq #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd_i      (in_cmd),
    .period_i   (in_period_ticks),
    .handle_i   (in_handle),
    .tag_i      (in_argument_tag),
    .now_i      (now_r),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .emit_vld_o (emit_vld),
    .emit_o     (emit)
  );

  osts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_strobe       = strobe_r;
  assign out_kind         = res_r.kind;
  assign out_slot         = res_r.slot;
  assign out_fired_handle = res_r.handle;
  assign out_fired_tag    = res_r.tag;
  assign out_last         = res_r.last;

  assign res_fire = out_strobe && (out_kind == KIND_FIRED);

  `OSTS_ASSERT_IMP(a_single_is_last, out_strobe && !res_fire, out_last, "result without last")
  `OSTS_ASSERT_IMP(a_fire_has_handle, res_fire, out_fired_handle != 16'd0, "null handle fired")
  `OSTS_ASSERT_NXT(a_arm_busy, start && !busy && (in_cmd == CMD_ARM), busy, "arm not started")
  `OSTS_ASSERT_NXT(a_tick_advance, tick_acc, now_r == $past(now_r) + 64'd1, "tick not counted")

endmodule

// ===== test/tb_top.sv =====
// Testbench for one_shot_timer_slot_table: arm, cancel and tick items with random sender gaps.
// Every report is checked against a local model of the slot table and the tick counter.
// Depends on osts_pkg and one_shot_timer_slot_table.
module tb_top;
  import osts_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;  // unknown command, ignored by the block
  localparam int CYCLE_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 3 * NUM_SLOTS_DEF + 8;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] period;
    logic [15:0] hnd;
    logic [31:0] tag;
  } timer_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [31:0] in_period_ticks;
  logic [15:0] in_handle;
  logic [31:0] in_argument_tag;
  logic        out_strobe;
  logic [2:0]  out_kind;
  logic [3:0]  out_slot;
  logic [15:0] out_fired_handle;
  logic [31:0] out_fired_tag;
  logic        out_last;

  timer_cmd_t cmd_q[$];
  result_t    report_q[$];

  // local copy of the slot table
  bit          tm_active[NUM_SLOTS_DEF];
  logic [63:0] tm_deadline[NUM_SLOTS_DEF];
  logic [15:0] tm_handle[NUM_SLOTS_DEF];
  logic [31:0] tm_tag[NUM_SLOTS_DEF];
  logic [63:0] tm_now;

  int err_cnt = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int burst_left = 0;

  one_shot_timer_slot_table DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_period_ticks  (in_period_ticks),
    .in_handle        (in_handle),
    .in_argument_tag  (in_argument_tag),
    .out_strobe       (out_strobe),
    .out_kind         (out_kind),
    .out_slot         (out_slot),
    .out_fired_handle (out_fired_handle),
    .out_fired_tag    (out_fired_tag),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic log_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // Applies one item to the table model and queues the reports it causes.
  function automatic void table_step(input timer_cmd_t c);
    result_t r;
    int      fired;
    bit      found;
    r = '0;
    r.last = 1'b1;
    fired = 0;
    found = 1'b0;
    case (c.cmd)
      CMD_ARM: begin
        r.kind = KIND_NOSPACE;
        for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
          if (!tm_active[i]) begin
            tm_active[i] = 1'b1;
            tm_deadline[i] = tm_now + {32'd0, c.period};
            tm_handle[i] = c.hnd;
            tm_tag[i] = c.tag;
            r.kind = KIND_ARMED;
            r.slot = 4'(i);
            break;
          end
        end
        report_q.push_back(r);
      end
      CMD_CANCEL: begin
        for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
          if (tm_active[i] && tm_handle[i] == c.hnd) begin
            tm_active[i] = 1'b0;
            tm_deadline[i] = '0;
            tm_handle[i] = '0;
            tm_tag[i] = '0;
            found = 1'b1;
          end
        end
        r.kind = found ? KIND_CANCELLED : KIND_NOTFOUND;
        report_q.push_back(r);
      end
      CMD_TICK: begin
        tm_now = tm_now + 64'd1;
        for (int i = 0; i < NUM_SLOTS_DEF && fired < MAX_REPORTS; i++) begin
          if (tm_active[i] && tm_deadline[i] < tm_now) begin
            tm_active[i] = 1'b0;
            // null handle expires silently
            if (tm_handle[i] != 16'd0) begin
              r.kind = KIND_FIRED;
              r.slot = 4'(i);
              r.handle = tm_handle[i];
              r.tag = tm_tag[i];
              r.last = 1'b0;
              report_q.push_back(r);
              fired++;
            end
          end
        end
        if (fired > 0) begin
          r = report_q.pop_back();
          r.last = 1'b1;
          report_q.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic present_next();
    timer_cmd_t c;
    c = cmd_q.pop_front();
    in_cmd <= c.cmd;
    in_period_ticks <= c.period;
    in_handle <= c.hnd;
    in_argument_tag <= c.tag;
  endtask

  // Driver: bursts of back-to-back items separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_cmd <= CMD_ARM;
      in_period_ticks <= '0;
      in_handle <= '0;
      in_argument_tag <= '0;
    end else if (start && !busy) begin
      if (burst_left > 0 && cmd_q.size() > 0) begin
        present_next();
        burst_left--;
      end else begin
        start <= 1'b0;
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() > 0) begin
        present_next();
        start <= 1'b1;
        burst_left = ($urandom_range(0, 7) == 0) ? 24 : $urandom_range(0, 7);
      end
    end
  end

  // Monitor: check reports, then model the item taken at this edge.
  always @(posedge clk) begin
    result_t    want;
    timer_cmd_t c;
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("RESULT: ERROR");
      $finish;
    end else if (!rst_n) begin
      tm_now = '0;
      for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
        tm_active[i] = 1'b0;
        tm_deadline[i] = '0;
        tm_handle[i] = '0;
        tm_tag[i] = '0;
      end
    end else begin
      if (out_strobe) begin
        if (report_q.size() == 0) begin
          log_mismatch($sformatf("unexpected report kind=%0d slot=%0d", out_kind, out_slot));
        end else begin
          want = report_q.pop_front();
          if (out_kind !== want.kind || out_slot !== want.slot ||
              out_fired_handle !== want.handle || out_fired_tag !== want.tag ||
              out_last !== want.last)
            log_mismatch($sformatf(
              "got kind=%0d slot=%0d hnd=%h tag=%h last=%b, want %0d %0d %h %h %b",
              out_kind, out_slot, out_fired_handle, out_fired_tag, out_last,
              want.kind, want.slot, want.handle, want.tag, want.last));
        end
      end
      if (start && !busy) begin
        c.cmd = in_cmd;
        c.period = in_period_ticks;
        c.hnd = in_handle;
        c.tag = in_argument_tag;
        table_step(c);
      end
    end
  end

  function automatic void add_item(input logic [1:0] cmd, input logic [31:0] period,
                                   input logic [15:0] hnd, input logic [31:0] tag);
    timer_cmd_t c;
    c.cmd = cmd;
    c.period = period;
    c.hnd = hnd;
    c.tag = tag;
    cmd_q.push_back(c);
  endfunction

  // small handle pool so that cancels find their timers
  function automatic logic [15:0] pick_handle();
    return ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
  endfunction

  initial begin
    int counted;
    int sel;
    rst_n = 1'b0;

    // null handle timer that expires on the first tick without a report
    add_item(CMD_ARM, 32'd0, 16'd0, 32'd0);
    add_item(CMD_TICK, 32'd0, 16'd0, 32'd0);
    // fill the whole table
    add_item(CMD_ARM, 32'd0, 16'hFFFF, 32'hFFFF_FFFF);
    add_item(CMD_ARM, 32'hFFFF_FFFF, 16'd0, 32'd0);
    add_item(CMD_ARM, 32'hFFFF_FFFF, 16'd3, 32'h1234_5678);
    add_item(CMD_ARM, 32'h8000_0000, 16'd3, 32'h8765_4321);
    for (int i = 4; i < NUM_SLOTS_DEF; i++)
      add_item(CMD_ARM, 32'(i % 3), 16'(i), $urandom);
    add_item(CMD_ARM, 32'd5, 16'd9, 32'hA5A5_5A5A);          // table full
    add_item(CMD_CANCEL, 32'd0, 16'd3, 32'd0);               // matches two slots
    add_item(CMD_CANCEL, 32'hFFFF_FFFF, 16'h1234, 32'hFFFF_FFFF);  // no match
    add_item(CMD_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_item(CMD_TICK, 32'd0, 16'd0, 32'd0);                 // many fire at once
    add_item(CMD_CANCEL, 32'd0, 16'd0, 32'd0);               // cancel of null handle
    add_item(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);

    counted = 0;
    while (counted < 80) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        add_item(CMD_ARM,
                 ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 6)),
                 pick_handle(), $urandom);
        counted++;
      end else if (sel < 55) begin
        add_item(CMD_CANCEL, $urandom, pick_handle(), $urandom);
        counted++;
      end else if (sel < 95) begin
        add_item(CMD_TICK, $urandom, 16'($urandom), $urandom);
        counted++;
      end else begin
        add_item(CMD_NONE, $urandom, 16'($urandom), $urandom);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (cmd_q.size() != 0 || start);
    do @(posedge clk); while (report_q.size() != 0 || busy);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (report_q.size() != 0)
      log_mismatch($sformatf("%0d reports never arrived", report_q.size()));
    if (err_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
